/* rtl/gbfs_pkg.sv */
`default_nettype none
package gbfs_pkg;

  // Graph size and derived widths
  localparam int unsigned VERTICES = 16;
  localparam int unsigned VW       = $clog2(VERTICES);
  localparam int unsigned QW       = VW + 1;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_WRITE = 2'd0;
  localparam opcode_t OP_RUN   = 2'd1;
  localparam opcode_t OP_CLEAR = 2'd2;

  typedef struct packed {
    opcode_t     opcode;
    logic [3:0]  row_index;
    logic [15:0] row_bits;
    logic [3:0]  start_vertex;
  } bfs_in_t;

  typedef struct packed {
    logic [3:0] visited_vertex;
    logic       last;
  } bfs_out_t;

  // Requests to the adjacency store
  typedef struct packed {
    logic                wr_en;
    logic [VW-1:0]       wr_row;
    logic [VERTICES-1:0] wr_bits;
    logic                rd_en;
    logic [VW-1:0]       rd_row;
  } adj_req_t;

  // Requests to the vertex queue
  typedef struct packed {
    logic          restart;
    logic          push;
    logic          pop;
    logic [VW-1:0] vertex;
  } q_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QREAD,
    ST_AREAD,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

/* rtl/gbfs_adj.sv */
`default_nettype none
module gbfs_adj (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire gbfs_pkg::adj_req_t                     req,
  output logic            [gbfs_pkg::VERTICES-1:0]    rd_bits_r
);

  logic [gbfs_pkg::VERTICES-1:0] rows_r [gbfs_pkg::VERTICES];

  // Write one row; clear every row on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(gbfs_pkg::VERTICES); i++) begin
        rows_r[i] <= '0;
      end
    end else if (req.wr_en) begin
      rows_r[req.wr_row] <= req.wr_bits;
    end
  end

  // Registered row read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_bits_r <= rows_r[req.rd_row];
    end
  end

endmodule
`default_nettype wire

/* rtl/gbfs_queue.sv */
`default_nettype none
module gbfs_queue (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire gbfs_pkg::q_cmd_t                  cmd,
  output logic            [gbfs_pkg::VW-1:0]     rd_vertex_r,
  output logic                                   empty
);

  logic [gbfs_pkg::VW-1:0] mem [gbfs_pkg::VERTICES];
  logic [gbfs_pkg::QW-1:0] head_r, head_nxt;
  logic [gbfs_pkg::QW-1:0] tail_r, tail_nxt;
  logic                    full;

  assign full  = (tail_r == gbfs_pkg::QW'(gbfs_pkg::VERTICES));
  assign empty = (head_r == tail_r);

  // Advance the pointers
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (cmd.restart) begin
      head_nxt = '0;
      tail_nxt = gbfs_pkg::QW'(1);
    end else begin
      if (cmd.pop) head_nxt = head_r + gbfs_pkg::QW'(1);
      if (cmd.push && !full) tail_nxt = tail_r + gbfs_pkg::QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  // Store pushed vertices
  always_ff @(posedge clk) begin
    if (cmd.restart) begin
      mem[0] <= cmd.vertex;
    end else if (cmd.push && !full) begin
      mem[tail_r[gbfs_pkg::VW-1:0]] <= cmd.vertex;
    end
  end

  // Registered read at the head
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      rd_vertex_r <= mem[head_r[gbfs_pkg::VW-1:0]];
    end
  end

endmodule
`default_nettype wire

/* rtl/graph_bfs_visit_order_unit.sv */
`default_nettype none
// Channel   Direction  Payload    Transfer when
// in_       input      bfs_in_t   in_valid && in_ready
// out_      output     bfs_out_t  out_valid && out_ready
//
// Write and clear commands complete in the idle state. Each emitted vertex of a
// run goes through a queue read, an adjacency read, a 16-step neighbour scan through
// one bit-test unit, and the emit step. The neighbour scan sets the rate.
// Reset (rst_n, synchronous) clears adjacency, visited set and queue pointers.
// A stalled output holds the emit step; the held result does not block input.
module graph_bfs_visit_order_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire gbfs_pkg::bfs_in_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output gbfs_pkg::bfs_out_t      out_data
);

  gbfs_pkg::state_t state_r, state_nxt;

  logic [gbfs_pkg::VERTICES-1:0] visited_r, visited_nxt;
  logic [gbfs_pkg::VW-1:0]       cur_r, cur_nxt;
  logic [gbfs_pkg::VW-1:0]       bit_r, bit_nxt;
  logic                          out_valid_r, out_valid_nxt;
  gbfs_pkg::bfs_out_t            out_data_r, out_data_nxt;

  gbfs_pkg::adj_req_t            adj_req;
  gbfs_pkg::q_cmd_t              q_cmd;
  logic [gbfs_pkg::VERTICES-1:0] row_bits;
  logic [gbfs_pkg::VW-1:0]       q_vertex;
  logic                          q_empty;

  logic in_xfer;
  logic out_free;
  logic edge_hit;

  gbfs_adj u_adj (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (adj_req),
    .rd_bits_r (row_bits)
  );

  gbfs_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (q_cmd),
    .rd_vertex_r (q_vertex),
    .empty       (q_empty)
  );

  assign in_ready  = (state_r == gbfs_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Shared bit-test unit: edge to an unvisited vertex at the scan position
  assign edge_hit = row_bits[bit_r] && !visited_r[bit_r];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gbfs_pkg::ST_IDLE: begin
        if (in_xfer && in_data.opcode == gbfs_pkg::OP_RUN) state_nxt = gbfs_pkg::ST_QREAD;
      end
      gbfs_pkg::ST_QREAD: state_nxt = gbfs_pkg::ST_AREAD;
      gbfs_pkg::ST_AREAD: state_nxt = gbfs_pkg::ST_SCAN;
      gbfs_pkg::ST_SCAN: begin
        if (bit_r == '0) state_nxt = gbfs_pkg::ST_EMIT;
      end
      gbfs_pkg::ST_EMIT: begin
        if (out_free) state_nxt = q_empty ? gbfs_pkg::ST_IDLE : gbfs_pkg::ST_QREAD;
      end
      default: state_nxt = gbfs_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    visited_nxt   = visited_r;
    cur_nxt       = cur_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    adj_req       = '0;
    q_cmd         = '0;
    unique case (state_r)
      gbfs_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_data.opcode)
            gbfs_pkg::OP_WRITE: begin
              adj_req.wr_en   = 1'b1;
              adj_req.wr_row  = in_data.row_index[gbfs_pkg::VW-1:0];
              adj_req.wr_bits = in_data.row_bits[gbfs_pkg::VERTICES-1:0];
            end
            gbfs_pkg::OP_RUN: begin
              visited_nxt[in_data.start_vertex[gbfs_pkg::VW-1:0]] = 1'b1;
              q_cmd.restart = 1'b1;
              q_cmd.vertex  = in_data.start_vertex[gbfs_pkg::VW-1:0];
            end
            gbfs_pkg::OP_CLEAR: visited_nxt = '0;
            default: ;
          endcase
        end
      end
      gbfs_pkg::ST_QREAD: begin
        q_cmd.pop = 1'b1;
      end
      gbfs_pkg::ST_AREAD: begin
        cur_nxt        = q_vertex;
        adj_req.rd_en  = 1'b1;
        adj_req.rd_row = q_vertex;
        bit_nxt        = '1;
      end
      gbfs_pkg::ST_SCAN: begin
        if (edge_hit) begin
          visited_nxt[bit_r] = 1'b1;
          q_cmd.push   = 1'b1;
          q_cmd.vertex = bit_r;
        end
        bit_nxt = bit_r - gbfs_pkg::VW'(1);
      end
      gbfs_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.visited_vertex = 4'(cur_r);
          out_data_nxt.last           = q_empty;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbfs_pkg::ST_IDLE;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      visited_r   <= visited_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    bit_r      <= bit_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire
